// ===== design/ntc_pkg.sv =====
// Package for the numeric type cast core: type codes, register indexes,
// and the configuration and decoded-value structs. No dependencies.
package ntc_pkg;

  localparam int ElemWidth = 32;
  localparam int TypeWidth = 3;
  localparam int AddrWidth = 3;

  typedef enum logic [TypeWidth-1:0] {
    TYPE_INT8   = 3'd0,
    TYPE_INT16  = 3'd1,
    TYPE_INT32  = 3'd2,
    TYPE_UINT32 = 3'd3,
    TYPE_FLOAT  = 3'd4,
    TYPE_BOOL   = 3'd5
  } elem_type_t;

  localparam logic [AddrWidth-1:0] AddrSourceType = 3'd0;
  localparam logic [AddrWidth-1:0] AddrTargetType = 3'd4;

  typedef struct packed {
    logic [TypeWidth-1:0] source_type;
    logic [TypeWidth-1:0] target_type;
  } cast_cfg_t;

  // Validity, sign, magnitude and raw value of an element after source decoding.
  typedef struct packed {
    logic                 valid;
    logic                 neg;
    logic [ElemWidth-1:0] mag;
    logic [ElemWidth-1:0] raw;
  } src_val_t;

endpackage

// ===== design/ntc_stream_if.sv =====
// Valid/ready stream interface carrying one element request.
// Depends on ntc_pkg.
interface ntc_stream_if;
  logic                          valid;
  logic                          ready;
  logic [ntc_pkg::ElemWidth-1:0] bits;
  logic                          last;

  modport source (output valid, output bits, output last, input ready);
  modport sink (input valid, input bits, input last, output ready);
endinterface

// ===== design/ntc_regs.sv =====
// APB configuration registers for source and target type.
// Depends on ntc_pkg.
module ntc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ntc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ntc_pkg::cast_cfg_t            cfg
);
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (paddr)
        ntc_pkg::AddrSourceType: cfg.source_type <= pwdata[ntc_pkg::TypeWidth-1:0];
        ntc_pkg::AddrTargetType: cfg.target_type <= pwdata[ntc_pkg::TypeWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr)
      ntc_pkg::AddrSourceType: prdata[ntc_pkg::TypeWidth-1:0] = cfg.source_type;
      ntc_pkg::AddrTargetType: prdata[ntc_pkg::TypeWidth-1:0] = cfg.target_type;
      default: prdata = '0;
    endcase
  end
endmodule

// ===== design/ntc_convert.sv =====
// Combinational conversion of one element between configured types.
// Depends on ntc_pkg.
module ntc_convert (
  input  ntc_pkg::cast_cfg_t            cfg,
  input  logic [ntc_pkg::ElemWidth-1:0] element_bits,
  output logic [ntc_pkg::ElemWidth-1:0] result_bits
);
  ntc_pkg::src_val_t sv;
  logic [4:0]  msb;
  logic [31:0] norm;
  logic [24:0] keep;
  logic        guard;
  logic        sticky;
  logic        rnd;
  logic [8:0]  expo;
  logic [31:0] f_out;
  logic [7:0]  fex;
  logic [31:0] fmag;
  logic        fhuge;
  logic        fneg;
  logic [54:0] fsh;
  logic [31:0] int_out;
  logic [31:0] ival;

  always_comb begin
    sv = '0;
    sv.valid = 1'b1;
    sv.raw = '0;
    case (cfg.source_type)
      ntc_pkg::TYPE_INT8:   sv.raw = {{24{element_bits[7]}}, element_bits[7:0]};
      ntc_pkg::TYPE_INT16:  sv.raw = {{16{element_bits[15]}}, element_bits[15:0]};
      ntc_pkg::TYPE_INT32:  sv.raw = element_bits;
      ntc_pkg::TYPE_UINT32: sv.raw = element_bits;
      ntc_pkg::TYPE_BOOL:   sv.raw = {31'd0, element_bits[7:0] != 8'd0};
      default:              sv.valid = 1'b0;
    endcase
    sv.neg = sv.raw[31] && cfg.source_type != ntc_pkg::TYPE_UINT32;
    sv.mag = sv.neg ? (~sv.raw + 32'd1) : sv.raw;
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (sv.mag[i]) msb = 5'(i);
    end
    norm   = sv.mag << (5'd31 - msb);
    keep   = {1'b0, norm[31:8]};
    guard  = norm[7];
    sticky = norm[6:0] != 7'd0;
    rnd    = guard && (sticky || keep[0]);
    keep   = keep + {24'd0, rnd};
    expo   = 9'd127 + {4'd0, msb} + {8'd0, keep[24]};
    f_out  = (sv.mag == '0) ? '0 :
             {sv.neg, expo[7:0], keep[24] ? keep[23:1] : keep[22:0]};
  end

  always_comb begin
    fex   = element_bits[30:23];
    fneg  = element_bits[31];
    fhuge = (fex == 8'hFF) || (fex >= 8'd159);
    fsh   = '0;
    if (fex >= 8'd127 && !fhuge) begin
      fsh = {31'd0, 1'b1, element_bits[22:0]} << (fex - 8'd127);
    end
    fmag = fsh[54:23];
  end

  always_comb begin
    ival = '0;
    if (fex == 8'hFF && element_bits[22:0] != '0) begin
      ival = '0;
    end else begin
      case (cfg.target_type)
        ntc_pkg::TYPE_INT8:
          ival = fneg ? ((fhuge || fmag > 32'h80) ? 32'hFFFFFF80 : ~fmag + 32'd1)
                      : ((fhuge || fmag > 32'h7F) ? 32'h7F : fmag);
        ntc_pkg::TYPE_INT16:
          ival = fneg ? ((fhuge || fmag > 32'h8000) ? 32'hFFFF8000 : ~fmag + 32'd1)
                      : ((fhuge || fmag > 32'h7FFF) ? 32'h7FFF : fmag);
        ntc_pkg::TYPE_INT32:
          ival = fneg ? ((fhuge || fmag > 32'h80000000) ? 32'h80000000 : ~fmag + 32'd1)
                      : ((fhuge || fmag > 32'h7FFFFFFF) ? 32'h7FFFFFFF : fmag);
        ntc_pkg::TYPE_UINT32:
          ival = fneg ? 32'd0 : (fhuge ? 32'hFFFFFFFF : fmag);
        default: ival = '0;
      endcase
    end
  end

  always_comb begin
    int_out = '0;
    if (cfg.source_type == ntc_pkg::TYPE_FLOAT) begin
      int_out = ival;
    end else if (sv.valid) begin
      int_out = sv.raw;
    end
  end

  always_comb begin
    result_bits = '0;
    if (cfg.source_type == ntc_pkg::TYPE_FLOAT) begin
      if (cfg.target_type == ntc_pkg::TYPE_FLOAT) result_bits = element_bits;
    end else if (sv.valid && cfg.target_type == ntc_pkg::TYPE_FLOAT) begin
      result_bits = f_out;
    end
    case (cfg.target_type)
      ntc_pkg::TYPE_INT8:   result_bits = {24'd0, int_out[7:0]};
      ntc_pkg::TYPE_INT16:  result_bits = {16'd0, int_out[15:0]};
      ntc_pkg::TYPE_INT32:  result_bits = int_out;
      ntc_pkg::TYPE_UINT32: result_bits = int_out;
      ntc_pkg::TYPE_FLOAT:  ;
      default:              result_bits = '0;
    endcase
  end
endmodule

// ===== design/numeric_type_cast_core.sv =====
// Top level of the numeric type cast core: input register, conversion
// logic, output register, APB registers. Depends on ntc_pkg and ntc_stream_if.
//
// Each request passes through the input register and the conversion logic into
// the output register; one request is accepted in every cycle while the output
// side takes results. Source and target type are written over APB at offsets 0
// and 4; the user must do so only while idle, which the block does not enforce.
module numeric_type_cast_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ntc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  ntc_stream_if.sink                    in_req,
  ntc_stream_if.source                  out_req
);
  ntc_pkg::cast_cfg_t            cfg;
  logic                          in_valid;
  logic [ntc_pkg::ElemWidth-1:0] in_bits;
  logic                          in_last;
  logic [ntc_pkg::ElemWidth-1:0] conv_bits;
  logic                          in_ready;
  logic                          out_ready;

  ntc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  ntc_convert u_convert (
    .cfg          (cfg),
    .element_bits (in_bits),
    .result_bits  (conv_bits)
  );

  assign out_ready    = !out_req.valid || out_req.ready;
  assign in_ready     = !in_valid || out_ready;
  assign in_req.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_req.valid <= 1'b0;
    end else begin
      if (in_ready) in_valid <= in_req.valid;
      if (out_ready) out_req.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_req.valid) begin
      in_bits <= in_req.bits;
      in_last <= in_req.last;
    end
    if (out_ready && in_valid) begin
      out_req.bits <= conv_bits;
      out_req.last <= in_last;
    end
  end
endmodule

// ===== test/ntc_checker.sv =====
// Checker for the numeric type cast core: watches both request channels,
// predicts each converted element and compares it. Depends on ntc_pkg.
module ntc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_bits,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_bits,
  input  logic        out_last,
  input  logic [2:0]  cfg_source,
  input  logic [2:0]  cfg_target,
  output int          fail_count,
  output int          pending_count,
  output logic        moved
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] bits;
    logic        last;
  } elem_t;

  elem_t converted_q[$];

  function automatic int unsigned int_bits(logic [2:0] t);
    case (t)
      ntc_pkg::TYPE_INT8: return 8;
      ntc_pkg::TYPE_INT16: return 16;
      ntc_pkg::TYPE_INT32, ntc_pkg::TYPE_UINT32: return 32;
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] to_float(logic neg, logic [63:0] mag);
    int unsigned p;
    int unsigned sh;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] expo;
    if (mag == 0) return 32'd0;
    p = 0;
    while (p < 63 && (mag >> (p + 1)) != 0) p++;
    expo = 127 + p;
    if (p <= 23) begin
      keep = mag << (23 - p);
    end else begin
      sh = p - 23;
      rem = mag & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      keep = mag >> sh;
      if (rem > half || (rem == half && keep[0])) begin
        keep = keep + 1;
        if (keep == (64'd1 << 24)) begin
          keep = keep >> 1;
          expo = expo + 1;
        end
      end
    end
    return {neg, 31'd0} | (expo << 23) | {9'd0, keep[22:0]};
  endfunction

  function automatic logic [31:0] float_to_int(logic [31:0] b, logic [2:0] t);
    int unsigned w;
    int unsigned e;
    logic huge;
    logic [63:0] mag;
    logic [63:0] pos_max;
    logic [63:0] neg_max;
    logic [63:0] mask;
    w = int_bits(t);
    huge = 0;
    mag = 0;
    if (b[30:23] == 8'hFF && b[22:0] != 0) return 32'd0;
    if (b[30:23] == 8'hFF) begin
      huge = 1;
    end else if (b[30:23] >= 127) begin
      e = b[30:23] - 127;
      if (e >= 32) begin
        huge = 1;
      end else begin
        mag = {41'd1, b[22:0]};
        if (e >= 23) mag = mag << (e - 23);
        else mag = mag >> (23 - e);
      end
    end
    mask = (w >= 32) ? 64'hFFFF_FFFF : ((64'd1 << w) - 1);
    if (t == ntc_pkg::TYPE_UINT32) begin
      pos_max = 64'hFFFF_FFFF;
      neg_max = 0;
    end else begin
      pos_max = (64'd1 << (w - 1)) - 1;
      neg_max = 64'd1 << (w - 1);
    end
    if (b[31]) begin
      if (huge || mag > neg_max) mag = neg_max;
      return 32'((64'd0 - mag) & mask);
    end
    if (huge || mag > pos_max) mag = pos_max;
    return 32'(mag & mask);
  endfunction

  function automatic logic [31:0] convert(logic [31:0] b, logic [2:0] s, logic [2:0] t);
    logic signed [63:0] val;
    logic [63:0] mag;
    int unsigned w;
    if (s == ntc_pkg::TYPE_FLOAT) begin
      if (t == ntc_pkg::TYPE_FLOAT) return b;
      if (int_bits(t) != 0) return float_to_int(b, t);
      return 32'd0;
    end
    case (s)
      ntc_pkg::TYPE_INT8: val = 64'(signed'(b[7:0]));
      ntc_pkg::TYPE_INT16: val = 64'(signed'(b[15:0]));
      ntc_pkg::TYPE_INT32: val = 64'(signed'(b));
      ntc_pkg::TYPE_UINT32: val = {32'd0, b};
      ntc_pkg::TYPE_BOOL: val = (b[7:0] != 0) ? 64'sd1 : 64'sd0;
      default: return 32'd0;
    endcase
    if (t == ntc_pkg::TYPE_FLOAT) begin
      mag = (val < 0) ? 64'(-val) : 64'(val);
      return to_float(val < 0, mag);
    end
    w = int_bits(t);
    if (w == 0) return 32'd0;
    return 32'(val & ((w >= 32) ? 64'hFFFF_FFFF : ((64'd1 << w) - 1)));
  endfunction

  assign pending_count = converted_q.size();
  assign moved = (in_valid && in_ready) || (out_valid && out_ready);

  always @(posedge clk) begin
    elem_t want;
    if (rst) begin
      converted_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        converted_q.push_back('{convert(in_bits, cfg_source, cfg_target), in_last});
      if (out_valid && out_ready) begin
        if (converted_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected result %h last %b", out_bits, out_last);
        end else begin
          want = converted_q.pop_front();
          if (want.bits !== out_bits || want.last !== out_last) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("Mismatch: expected %h last %b, got %h last %b",
                       want.bits, want.last, out_bits, out_last);
          end
        end
      end
    end
  end
endmodule

// ===== test/testbench.sv =====
// Top of the numeric type cast testbench: clock, reset, APB setup, stimulus
// and verdict. Depends on ntc_pkg, ntc_stream_if, the core and ntc_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic [2:0]  cfg_source;
  logic [2:0]  cfg_target;
  logic        hold_off;
  logic        moved;
  int          fail_count;
  int          pending_count;
  int          idle_cycles;

  ntc_stream_if in_req ();
  ntc_stream_if out_req ();

  numeric_type_cast_core DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_req(in_req.sink), .out_req(out_req.source)
  );

  ntc_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_req.valid), .in_ready(in_req.ready), .in_bits(in_req.bits),
    .in_last(in_req.last),
    .out_valid(out_req.valid), .out_ready(out_req.ready), .out_bits(out_req.bits),
    .out_last(out_req.last),
    .cfg_source(cfg_source), .cfg_target(cfg_target),
    .fail_count(fail_count), .pending_count(pending_count), .moved(moved)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic write_reg(logic [2:0] addr, logic [2:0] value);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= {29'd0, value};
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ntc_pkg::AddrSourceType) cfg_source = value;
    else cfg_target = value;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_element(logic [31:0] bits, logic last);
    in_req.valid <= 1;
    in_req.bits <= bits;
    in_req.last <= last;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_element(logic [2:0] s);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: r = 32'd0;
      1: r = 32'hFFFF_FFFF;
      2: r = {r[31], 8'hFF, r[22:0]};
      3: r = {r[31], 8'd127 + 8'($urandom_range(0, 40)), r[22:0]};
      4: r = 32'h8000_0000 ^ (32'd1 << $urandom_range(0, 31));
      default: ;
    endcase
    if (s == ntc_pkg::TYPE_FLOAT && r[30:23] > 8'd170 && r[30:23] != 8'hFF &&
        $urandom_range(0, 1))
      r[30:23] = 8'd127 + 8'($urandom_range(0, 34));
    return r;
  endfunction

  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_burst(int count, logic [2:0] s);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) == 0) begin
        in_req.valid <= 0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      repeat ($urandom_range(1, 12)) begin
        if (sent < count) begin
          send_element(random_element(s), $urandom_range(0, 1));
          sent++;
        end
      end
    end
    in_req.valid <= 0;
  endtask

  initial begin
    out_req.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_req.ready <= 0;
      end else begin
        case ($urandom_range(0, 5))
          0: out_req.ready <= 0;
          1: out_req.ready <= ~out_req.ready;
          default: out_req.ready <= 1;
        endcase
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || moved) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] corner[13];
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_req.valid = 0; in_req.bits = 0; in_req.last = 0;
    cfg_source = ntc_pkg::TYPE_INT8; cfg_target = ntc_pkg::TYPE_INT8;
    hold_off = 0;
    rst = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;
    corner = '{32'd0, 32'hFFFF_FFFF, 32'h0000_0080, 32'h0000_7FFF, 32'h8000_0000,
               32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'h4F00_0000,
               32'hCF00_0000, 32'h3F7F_FFFF, 32'h0100_0001, 32'hFFFF_FF00};
    for (int s = ntc_pkg::TYPE_INT8; s <= ntc_pkg::TYPE_BOOL; s++) begin
      for (int t = ntc_pkg::TYPE_INT8; t <= ntc_pkg::TYPE_FLOAT; t++) begin
        write_reg(ntc_pkg::AddrSourceType, 3'(s));
        write_reg(ntc_pkg::AddrTargetType, 3'(t));
        if (s == ntc_pkg::TYPE_INT8 && t == ntc_pkg::TYPE_INT8)
          foreach (corner[i]) send_element(corner[i], i[0]);
        else begin
          send_element(corner[$urandom_range(0, 12)], 1);
          send_element(corner[$urandom_range(0, 12)], 0);
        end
        in_req.valid <= 0;
        run_burst(50, 3'(s));
        if (s == ntc_pkg::TYPE_FLOAT && t == ntc_pkg::TYPE_INT32) begin
          hold_off = 1;
          fork
            begin
              repeat (200) @(posedge clk);
              hold_off = 0;
            end
            run_burst(20, 3'(s));
          join
        end
        drain();
      end
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== numeric_type_cast_core.f =====
design/ntc_pkg.sv
design/ntc_stream_if.sv
design/ntc_regs.sv
design/ntc_convert.sv
design/numeric_type_cast_core.sv
test/ntc_checker.sv
test/testbench.sv
